>>> hdl/screen_damage_box_tracker_macros.svh
// ----------------------------------------------------------------------------
// Screen damage box tracker assertion macros
// Shorthand for clocked concurrent checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SCREEN_DAMAGE_BOX_TRACKER_MACROS_SVH
`define SCREEN_DAMAGE_BOX_TRACKER_MACROS_SVH

// Same-cycle implication.
`define SDBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sdbt_pkg.sv
// ----------------------------------------------------------------------------
// Screen damage box tracker package
// Item types, operation codes, command format and the box clip function.
// ----------------------------------------------------------------------------
package sdbt_pkg;

    // Operation codes of an input item
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_CELLS  = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_FULL   = 3'd3;
    localparam logic [2:0] OP_OFFSET = 3'd4;

    // Command kinds passed from front to back
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_CLEAR = 2'd1;
    localparam logic [1:0] K_ADD   = 2'd2;
    localparam logic [1:0] K_FULL  = 2'd3;

    // Box coordinates on the canvas (covers canvases up to 4095 pixels)
    localparam int C_COORD_W = 12;
    // Unclipped pixel arithmetic on cell and cursor positions
    localparam int C_WIDE_W  = 14;

    localparam int         C_CELL_PX_W    = 6;
    localparam int         C_CELL_PX_H    = 16;
    localparam int         C_CURSOR_SIZE  = 16;
    localparam logic [7:0] C_CURSOR_HIDDEN = 8'hD8;
    localparam logic [7:0] C_OFFSET_MASK  = 8'h07;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] h_pos;
        logic [7:0] v_pos;
        logic [7:0] cells_wide;
        logic [7:0] cells_high;
        logic [7:0] offset_value;
    } t_in_item;

    typedef struct packed {
        logic       fb_changed;
        logic       whole_screen;
        logic [8:0] box_x;
        logic [8:0] box_y;
        logic [9:0] box_w;
        logic [8:0] box_h;
        logic       offset_taken;
    } t_out_item;

    // Clipped box as start and end corners; end is exclusive
    typedef struct packed {
        logic                 valid;
        logic [C_COORD_W-1:0] x0;
        logic [C_COORD_W-1:0] y0;
        logic [C_COORD_W-1:0] x1;
        logic [C_COORD_W-1:0] y1;
    } t_box;

    typedef struct packed {
        logic [1:0] kind;
        logic       touch;
        logic       taken;
        t_box       box_a;
        t_box       box_b;
    } t_cmd;

    // Cut a box at the right and bottom canvas edges; drop it if nothing is left.
    function automatic t_box clip_box(
        input logic [C_WIDE_W-1:0] x,
        input logic [C_WIDE_W-1:0] y,
        input logic [C_WIDE_W-1:0] w,
        input logic [C_WIDE_W-1:0] h,
        input logic [C_WIDE_W-1:0] cw,
        input logic [C_WIDE_W-1:0] ch
    );
        t_box                b;
        logic [C_WIDE_W-1:0] ex;
        logic [C_WIDE_W-1:0] ey;
        ex      = x + w;
        ey      = y + h;
        b.valid = (w != '0) && (h != '0) && (x < cw) && (y < ch);
        b.x0    = x[C_COORD_W-1:0];
        b.y0    = y[C_COORD_W-1:0];
        b.x1    = (ex > cw) ? cw[C_COORD_W-1:0] : ex[C_COORD_W-1:0];
        b.y1    = (ey > ch) ? ch[C_COORD_W-1:0] : ey[C_COORD_W-1:0];
        return b;
    endfunction

endpackage

>>> hdl/screen_damage_box_tracker.sv
// ----------------------------------------------------------------------------
// Screen damage box tracker
// Widens one screen damage box with each display event and reports it; a clear item empties it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_data (t_in_item)
//  output  | out       | o_valid / i_stall  | o_data (t_out_item)
//
// One item per cycle sustained while i_stall is low; each item is queued, then merged into a registered result.
// The front end decodes and clips in the accept cycle, the back end merges
// the box and registers the result from a two-entry queue.
// Reset clears the box, flags, cursor state and display offset.
// A stalled output holds its result; o_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`include "screen_damage_box_tracker_macros.svh"

module screen_damage_box_tracker
    import sdbt_pkg::*;
#(
    parameter int CANVAS_WIDTH  = 512,
    parameter int CANVAS_HEIGHT = 424
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic       in_accept;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    logic       q_empty;
    logic       q_full;
    logic [1:0] q_count;
    logic       back_take;

    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    sdbt_front #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_data),
        .o_cmd    (front_cmd)
    );

    sdbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .i_pop   (back_take),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    sdbt_back #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_take  (back_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    `SDBT_ASSERT_NXT(a_accept_queued, i_clk, i_rst_n, in_accept, q_count != 2'd0, "accepted item not queued")
    `SDBT_ASSERT_IMP(a_whole_touched, i_clk, i_rst_n, o_valid && o_data.whole_screen, o_data.fb_changed, "whole screen without framebuffer change")
    `SDBT_ASSERT_IMP(a_offset_full, i_clk, i_rst_n, o_valid && o_data.offset_taken, o_data.whole_screen, "taken offset did not invalidate screen")

endmodule

>>> hdl/sdbt_front.sv
// ----------------------------------------------------------------------------
// Screen damage box tracker front end
// Decodes an item, tracks cursor and display offset, builds clipped boxes.
// ----------------------------------------------------------------------------
module sdbt_front
    import sdbt_pkg::*;
#(
    parameter int CANVAS_WIDTH  = 512,
    parameter int CANVAS_HEIGHT = 424
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    localparam logic [C_WIDE_W-1:0] LP_CW = C_WIDE_W'(CANVAS_WIDTH);
    localparam logic [C_WIDE_W-1:0] LP_CH = C_WIDE_W'(CANVAS_HEIGHT);
    localparam logic [C_WIDE_W-1:0] LP_CURSOR = C_WIDE_W'(C_CURSOR_SIZE);

    logic       r_cursor_known, n_cursor_known;
    logic       r_cursor_shown, n_cursor_shown;
    logic [7:0] r_cursor_h, n_cursor_h;
    logic [7:0] r_cursor_v, n_cursor_v;
    logic [7:0] r_row_offset, n_row_offset;

    logic [C_WIDE_W-1:0] cell_x, cell_y, cell_w, cell_h;
    logic [C_WIDE_W-1:0] old_x, old_y, new_x, new_y;
    logic                old_on, new_on;
    t_box                cell_box, old_box, new_box;

    always_comb begin
        cell_x = C_WIDE_W'(i_item.h_pos) * C_WIDE_W'(C_CELL_PX_W);
        cell_y = (C_WIDE_W'(r_row_offset) + (C_WIDE_W'(i_item.v_pos) << 3)) << 1;
        cell_w = C_WIDE_W'(i_item.cells_wide) * C_WIDE_W'(C_CELL_PX_W);
        cell_h = C_WIDE_W'(i_item.cells_high) * C_WIDE_W'(C_CELL_PX_H);
        old_x  = C_WIDE_W'(r_cursor_h) << 1;
        old_y  = (C_WIDE_W'(r_cursor_v) + C_WIDE_W'(1)) << 1;
        new_x  = C_WIDE_W'(i_item.h_pos) << 1;
        new_y  = (C_WIDE_W'(i_item.v_pos) + C_WIDE_W'(1)) << 1;
        old_on = r_cursor_known && r_cursor_shown;
        new_on = (i_item.v_pos != C_CURSOR_HIDDEN);

        cell_box = clip_box(cell_x, cell_y, cell_w, cell_h, LP_CW, LP_CH);
        old_box  = clip_box(old_x, old_y, LP_CURSOR, LP_CURSOR, LP_CW, LP_CH);
        new_box  = clip_box(new_x, new_y, LP_CURSOR, LP_CURSOR, LP_CW, LP_CH);
        old_box.valid = old_box.valid && old_on;
        new_box.valid = new_box.valid && new_on;
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.kind        = K_NONE;
        n_cursor_known    = r_cursor_known;
        n_cursor_shown    = r_cursor_shown;
        n_cursor_h        = r_cursor_h;
        n_cursor_v        = r_cursor_v;
        n_row_offset      = r_row_offset;
        case (i_item.operation)
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
            end
            OP_CELLS: begin
                o_cmd.kind  = K_ADD;
                o_cmd.touch = 1'b1;
                o_cmd.box_a = cell_box;
            end
            OP_CURSOR: begin
                o_cmd.kind     = K_ADD;
                o_cmd.touch    = old_on || new_on;
                o_cmd.box_a    = old_box;
                o_cmd.box_b    = new_box;
                n_cursor_known = 1'b1;
                n_cursor_shown = new_on;
                n_cursor_h     = i_item.h_pos;
                n_cursor_v     = i_item.v_pos;
            end
            OP_FULL: begin
                o_cmd.kind  = K_FULL;
                o_cmd.touch = 1'b1;
            end
            OP_OFFSET: begin
                // take only offsets on a whole cell row
                if ((i_item.offset_value & C_OFFSET_MASK) == '0) begin
                    o_cmd.kind   = K_FULL;
                    o_cmd.touch  = 1'b1;
                    o_cmd.taken  = 1'b1;
                    n_row_offset = i_item.offset_value;
                end
            end
            default: begin
                o_cmd.kind = K_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_known <= 1'b0;
            r_cursor_shown <= 1'b0;
            r_cursor_h     <= '0;
            r_cursor_v     <= '0;
            r_row_offset   <= '0;
        end else if (i_accept) begin
            r_cursor_known <= n_cursor_known;
            r_cursor_shown <= n_cursor_shown;
            r_cursor_h     <= n_cursor_h;
            r_cursor_v     <= n_cursor_v;
            r_row_offset   <= n_row_offset;
        end
    end

endmodule

>>> hdl/sdbt_queue.sv
// ----------------------------------------------------------------------------
// Screen damage box tracker command queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module sdbt_queue
    import sdbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_cmd,
    output logic       o_empty,
    output logic       o_full,
    output logic [1:0] o_count
);

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'(DEPTH));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/sdbt_back.sv
// ----------------------------------------------------------------------------
// Screen damage box tracker back end
// Applies commands to the damage box and registers the result item.
// ----------------------------------------------------------------------------
module sdbt_back
    import sdbt_pkg::*;
#(
    parameter int CANVAS_WIDTH  = 512,
    parameter int CANVAS_HEIGHT = 424
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam logic [C_COORD_W-1:0] LP_CW = C_COORD_W'(CANVAS_WIDTH);
    localparam logic [C_COORD_W-1:0] LP_CH = C_COORD_W'(CANVAS_HEIGHT);

    t_box      r_box, n_box;
    logic      r_full, n_full;
    logic      r_touched, n_touched;
    logic      r_valid;
    t_out_item r_out, n_out;
    t_box      mrg_a, mrg_b;
    logic [C_COORD_W-1:0] box_w, box_h;

    // Smallest box holding both; an invalid side contributes nothing.
    function automatic t_box merge_box(input t_box cur, input t_box add);
        t_box m;
        if (!add.valid) begin
            m = cur;
        end else if (!cur.valid) begin
            m = add;
        end else begin
            m.valid = 1'b1;
            m.x0    = (add.x0 < cur.x0) ? add.x0 : cur.x0;
            m.y0    = (add.y0 < cur.y0) ? add.y0 : cur.y0;
            m.x1    = (add.x1 > cur.x1) ? add.x1 : cur.x1;
            m.y1    = (add.y1 > cur.y1) ? add.y1 : cur.y1;
        end
        return m;
    endfunction

    assign o_cmd_take = i_cmd_valid && (!r_valid || !i_stall);
    assign o_valid    = r_valid;
    assign o_data     = r_out;

    always_comb begin
        mrg_a     = merge_box(r_box, i_cmd.box_a);
        mrg_b     = merge_box(mrg_a, i_cmd.box_b);
        n_box     = r_box;
        n_full    = r_full;
        n_touched = r_touched;
        case (i_cmd.kind)
            K_CLEAR: begin
                n_box     = '0;
                n_full    = 1'b0;
                n_touched = 1'b0;
            end
            K_ADD: begin
                n_touched = r_touched || i_cmd.touch;
                // ignore new damage once the whole canvas is marked
                if (!r_full) begin
                    n_box = mrg_b;
                end
            end
            K_FULL: begin
                n_box.valid = 1'b1;
                n_box.x0    = '0;
                n_box.y0    = '0;
                n_box.x1    = LP_CW;
                n_box.y1    = LP_CH;
                n_full      = 1'b1;
                n_touched   = 1'b1;
            end
            default: begin
                n_box = r_box;
            end
        endcase

        box_w              = n_box.x1 - n_box.x0;
        box_h              = n_box.y1 - n_box.y0;
        n_out.fb_changed   = n_touched;
        n_out.whole_screen = n_full;
        n_out.box_x        = n_box.x0[8:0];
        n_out.box_y        = n_box.y0[8:0];
        n_out.box_w        = box_w[9:0];
        n_out.box_h        = box_h[8:0];
        n_out.offset_taken = i_cmd.taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box     <= '0;
            r_full    <= 1'b0;
            r_touched <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_box     <= n_box;
                r_full    <= n_full;
                r_touched <= n_touched;
                r_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_out <= n_out;
        end
    end

endmodule
